@@ rtl/core/modem_result_code_matcher_macros.svh @@
// assertion macros shared by the result code matcher modules
`ifndef MODEM_RESULT_CODE_MATCHER_MACROS_SVH
`define MODEM_RESULT_CODE_MATCHER_MACROS_SVH

// same-cycle implication, clocked on clk, off while in reset
`define MRCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define MRCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mrcm_pkg.sv @@
// types, code tables and helpers for the modem result code matcher
package mrcm_pkg;

  localparam int unsigned NUM_CODES   = 26;
  localparam int unsigned CODE_CHARS  = 13;
  localparam int unsigned CODE_BITS   = 8 * CODE_CHARS;
  localparam int unsigned MAX_LINE_DEF = 40;
  localparam int unsigned CNT_W       = 6;

  localparam logic [3:0] MSG_NONE       = 4'd14;
  localparam logic [3:0] MSG_LAST_RATE  = 4'd3;
  localparam logic [3:0] MSG_LAST_ERROR = 4'd8;

  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_LF      = 8'd10;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic [NUM_CODES-1:0] ALL_ALIVE = {NUM_CODES{1'b1}};

  typedef enum logic [1:0] {
    OUT_FAILED    = 2'd0,
    OUT_CONNECTED = 2'd1,
    OUT_ERROR     = 2'd2
  } outcome_t;

  typedef struct packed {
    logic       hit;
    outcome_t   outcome;
    logic [3:0] message_code;
    logic       set_rate;
    logic [2:0] rate_index;
  } res_t;

  // strings are right aligned: last character in the low byte
  localparam logic [CODE_BITS-1:0] CODE_STR [NUM_CODES] = '{
    "CONNECT", "1",
    "CONNECT 1200", "5", "15",
    "CONNECT 2400", "10", "16",
    "CONNECT 9600", "13", "17",
    "NO CARRIER", "3",
    "ERROR", "4",
    "NO DIALTONE", "6",
    "BUSY", "7",
    "NO ANSWER", "8",
    "CONNECT 12000",
    "CONNECT 14400",
    "CONNECT 19200",
    "CONNECT 38400",
    "CONNECT 57600"
  };

  localparam int unsigned CODE_LEN [NUM_CODES] = '{
    7, 1, 12, 1, 2, 12, 2, 2, 12, 2, 2, 10, 1,
    5, 1, 11, 1, 4, 1, 9, 1, 13, 13, 13, 13, 13
  };

  localparam int unsigned CODE_MSG [NUM_CODES] = '{
    0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 4,
    5, 5, 6, 6, 7, 7, 8, 8, 9, 10, 11, 12, 13
  };

  // character at position p of code i, counted from the start of the code
  function automatic logic [7:0] code_byte(input int unsigned i, input int unsigned p);
    logic [CODE_BITS-1:0] s;
    s = CODE_STR[i];
    if (p < CODE_LEN[i]) begin
      code_byte = s[8*(CODE_LEN[i]-1-p) +: 8];
    end else begin
      code_byte = 8'h00;
    end
  endfunction

  function automatic logic [2:0] msg_rate(input logic [1:0] m);
    logic [2:0] r;
    unique case (m)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd1;
      2'd2:    r = 3'd2;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/mrcm_line_match.sv @@
// line state and parallel per-code prefix match for the result code matcher
`include "modem_result_code_matcher_macros.svh"

module mrcm_line_match #(
  parameter int unsigned MAX_LINE = mrcm_pkg::MAX_LINE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                give_up,
  output mrcm_pkg::res_t      res
);
  import mrcm_pkg::*;

  logic [CNT_W-1:0]     char_count_r, char_count_nxt;
  logic [NUM_CODES-1:0] alive_mask_r, alive_mask_nxt;
  logic [NUM_CODES-1:0] keep;
  logic [7:0]           ch;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 is_eol;
  logic                 found;
  logic [3:0]           found_msg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= '0;
      alive_mask_r <= ALL_ALIVE;
    end else begin
      char_count_r <= char_count_nxt;
      alive_mask_r <= alive_mask_nxt;
    end
  end

  // case fold and per-code compare at the current position
  always_comb begin
    if (rx_byte >= CHAR_LOW_A && rx_byte <= CHAR_LOW_Z) begin
      ch = rx_byte - CASE_OFFSET;
    end else begin
      ch = rx_byte;
    end
    for (int unsigned i = 0; i < NUM_CODES; i++) begin
      keep[i] = 1'b0;
      for (int unsigned p = 0; p < CODE_CHARS; p++) begin
        if (p < CODE_LEN[i] && char_count_r == CNT_W'(p) && ch == code_byte(i, p)) begin
          keep[i] = 1'b1;
        end
      end
    end
  end

  // lowest-index live code whose length equals the line length
  always_comb begin
    found     = 1'b0;
    found_msg = MSG_NONE;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (alive_mask_r[i] && char_count_r == CNT_W'(CODE_LEN[i])) begin
        found     = 1'b1;
        found_msg = 4'(CODE_MSG[i]);
      end
    end
  end

  assign is_eol  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign cnt_inc = char_count_r + CNT_W'(1);

  always_comb begin
    res.hit          = 1'b0;
    res.outcome      = OUT_FAILED;
    res.message_code = MSG_NONE;
    res.set_rate     = 1'b0;
    res.rate_index   = 3'd0;
    char_count_nxt   = char_count_r;
    alive_mask_nxt   = alive_mask_r;
    if (step) begin
      priority if (give_up) begin
        res.hit        = 1'b1;
        char_count_nxt = '0;
        alive_mask_nxt = ALL_ALIVE;
      end else if (is_eol) begin
        char_count_nxt = '0;
        alive_mask_nxt = ALL_ALIVE;
        if (found) begin
          res.hit          = 1'b1;
          res.message_code = found_msg;
          priority if (found_msg <= MSG_LAST_RATE) begin
            res.outcome    = OUT_CONNECTED;
            res.set_rate   = 1'b1;
            res.rate_index = msg_rate(found_msg[1:0]);
          end else if (found_msg <= MSG_LAST_ERROR) begin
            res.outcome = OUT_ERROR;
          end else begin
            res.outcome = OUT_CONNECTED;
          end
        end
      end else if (cnt_inc >= CNT_W'(MAX_LINE)) begin
        res.hit        = 1'b1;
        char_count_nxt = '0;
        alive_mask_nxt = ALL_ALIVE;
      end else begin
        char_count_nxt = cnt_inc;
        alive_mask_nxt = alive_mask_r & keep;
      end
    end
  end

  `MRCM_ASSERT_NOW(a_count_below_limit, 1'b1, char_count_r < CNT_W'(MAX_LINE),
    "line count reached the length limit")
  `MRCM_ASSERT_NOW(a_empty_line_all_alive, char_count_r == '0, alive_mask_r == ALL_ALIVE,
    "empty line with codes already ruled out")
  `MRCM_ASSERT_NEXT(a_hit_clears_line, step && res.hit,
    char_count_r == '0 && alive_mask_r == ALL_ALIVE, "line state not cleared after result")

endmodule

@@ rtl/core/modem_result_code_matcher.sv @@
// top level of the modem result code matcher
// Usage:
//   in_ channel: one received modem byte per request (in_rx_byte), or an
//   abort request (in_give_up = 1) for a line timeout or keyboard abort.
//   out_ channel: zero or one result per request: outcome, message code,
//   and for plain connect and 1200/2400/9600 connects a rate change.
//   Lines end at CR or LF and are matched without regard to letter case;
//   empty or unknown lines give no result. A line reaching MAX_LINE
//   characters, or an abort, gives a failure with message code 14.
// Timing:
//   a request is held in the input register until the result register is free
//   or being taken; the match then updates the line state and loads the result
//   register, and out_valid rises with that load. One request per cycle is
//   sustained with out_ready high; the per-code match is one level of compare logic.
// Reset: line state cleared, both registers empty.
// Stall: while a result waits for out_ready, one more request is held in
//   the input register; then in_ready drops until the result is taken.
`include "modem_result_code_matcher_macros.svh"

module modem_result_code_matcher #(
  parameter int unsigned MAX_LINE = mrcm_pkg::MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_give_up,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_outcome,
  output logic [3:0] out_message_code,
  output logic       out_set_rate,
  output logic [2:0] out_rate_index
);
  import mrcm_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_rx_byte_r;
  logic       in_give_up_r;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;
  res_t       res;
  logic       step;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  mrcm_line_match #(
    .MAX_LINE (MAX_LINE)
  ) u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte_r),
    .give_up (in_give_up_r),
    .res     (res)
  );

  always_comb begin
    in_valid_nxt = (in_valid_r && !step) || (in_valid && in_ready);
    if (step) begin
      out_valid_nxt = res.hit;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_rx_byte_r <= in_rx_byte;
      in_give_up_r <= in_give_up;
    end
    if (step && res.hit) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_res_r.outcome;
  assign out_message_code = out_res_r.message_code;
  assign out_set_rate     = out_res_r.set_rate;
  assign out_rate_index   = out_res_r.rate_index;

  `MRCM_ASSERT_NOW(a_fail_no_message, out_valid_r && out_res_r.outcome == OUT_FAILED,
    out_res_r.message_code == MSG_NONE && !out_res_r.set_rate, "failure carries a message")
  `MRCM_ASSERT_NOW(a_rate_only_slow_connect, out_valid_r && out_res_r.set_rate,
    out_res_r.outcome == OUT_CONNECTED && out_res_r.message_code <= MSG_LAST_RATE,
    "rate change on a result without one")
  `MRCM_ASSERT_NOW(a_rate_needs_set, out_valid_r && out_res_r.rate_index != 3'd0,
    out_res_r.set_rate, "rate index without rate change")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the modem result code matcher
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrcm_pkg::*;

  localparam int unsigned LINE_LIMIT = MAX_LINE_DEF;
  localparam int unsigned CODE_COUNT = 26;
  localparam int unsigned RAND_ITEMS = 1215;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;

  localparam logic [3:0] M_CONNECT     = 4'd0;
  localparam logic [3:0] M_1200        = 4'd1;
  localparam logic [3:0] M_2400        = 4'd2;
  localparam logic [3:0] M_9600        = 4'd3;
  localparam logic [3:0] M_NO_CARRIER  = 4'd4;
  localparam logic [3:0] M_ERROR       = 4'd5;
  localparam logic [3:0] M_NO_DIALTONE = 4'd6;
  localparam logic [3:0] M_BUSY        = 4'd7;
  localparam logic [3:0] M_NO_ANSWER   = 4'd8;
  localparam logic [3:0] M_12000       = 4'd9;
  localparam logic [3:0] M_14400       = 4'd10;
  localparam logic [3:0] M_19200       = 4'd11;
  localparam logic [3:0] M_38400       = 4'd12;
  localparam logic [3:0] M_57600       = 4'd13;

  localparam logic [2:0] RATE_DEFAULT = 3'd0;
  localparam logic [2:0] RATE_9600    = 3'd4;

  typedef struct packed {
    outcome_t   outcome;
    logic [3:0] msg;
    logic       set_rate;
    logic [2:0] rate;
  } reply_t;

  typedef struct {
    logic [7:0] rx;
    logic       gu;
    bit         drain;
  } req_t;

  string result_text [CODE_COUNT] = '{
    "CONNECT", "1",
    "CONNECT 1200", "5", "15",
    "CONNECT 2400", "10", "16",
    "CONNECT 9600", "13", "17",
    "NO CARRIER", "3",
    "ERROR", "4",
    "NO DIALTONE", "6",
    "BUSY", "7",
    "NO ANSWER", "8",
    "CONNECT 12000", "CONNECT 14400", "CONNECT 19200",
    "CONNECT 38400", "CONNECT 57600"
  };

  logic [3:0] result_msg [CODE_COUNT] = '{
    M_CONNECT, M_CONNECT,
    M_1200, M_1200, M_1200,
    M_2400, M_2400, M_2400,
    M_9600, M_9600, M_9600,
    M_NO_CARRIER, M_NO_CARRIER,
    M_ERROR, M_ERROR,
    M_NO_DIALTONE, M_NO_DIALTONE,
    M_BUSY, M_BUSY,
    M_NO_ANSWER, M_NO_ANSWER,
    M_12000, M_14400, M_19200, M_38400, M_57600
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic in_give_up = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_outcome;
  logic [3:0] out_message_code;
  logic out_set_rate;
  logic [2:0] out_rate_index;

  req_t   pend_q [$];
  reply_t replies_q [$];

  int unsigned line_len = 0;
  logic [CODE_COUNT-1:0] live_codes = '1;
  int unsigned err_cnt = 0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned idle_cnt = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  modem_result_code_matcher #(
    .MAX_LINE(LINE_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .in_give_up(in_give_up),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_outcome(out_outcome),
    .out_message_code(out_message_code),
    .out_set_rate(out_set_rate),
    .out_rate_index(out_rate_index)
  );

  always #5 clk = ~clk;

  // line matcher prediction, one request at a time
  function automatic bit scan_byte(input logic [7:0] ch, input logic gu, output reply_t r);
    logic [7:0] up;
    logic [3:0] m;
    r = '{OUT_FAILED, MSG_NONE, 1'b0, RATE_DEFAULT};
    if (gu) begin
      line_len = 0;
      live_codes = '1;
      return 1'b1;
    end
    if (ch == CHAR_CR || ch == CHAR_LF) begin
      for (int i = 0; i < CODE_COUNT; i++) begin
        if (live_codes[i] && result_text[i].len() == line_len) begin
          m = result_msg[i];
          r.msg = m;
          if (m <= MSG_LAST_RATE) begin
            r.outcome = OUT_CONNECTED;
            r.set_rate = 1'b1;
            r.rate = (m == M_9600) ? RATE_9600 : 3'(m);
          end else if (m <= MSG_LAST_ERROR) begin
            r.outcome = OUT_ERROR;
          end else begin
            r.outcome = OUT_CONNECTED;
          end
          line_len = 0;
          live_codes = '1;
          return 1'b1;
        end
      end
      line_len = 0;
      live_codes = '1;
      return 1'b0;
    end
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    for (int i = 0; i < CODE_COUNT; i++) begin
      if (!(line_len < result_text[i].len() && 8'(result_text[i][line_len]) == up)) begin
        live_codes[i] = 1'b0;
      end
    end
    line_len++;
    if (line_len >= LINE_LIMIT) begin
      line_len = 0;
      live_codes = '1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [7:0] pick_term();
    return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
  endfunction

  task automatic push(input logic [7:0] b, input logic gu);
    pend_q.push_back('{b, gu, 1'b0});
  endtask

  task automatic push_text(input string s, input bit mix, input int unsigned keep);
    logic [7:0] c;
    for (int k = 0; k < keep && k < s.len(); k++) begin
      c = 8'(s[k]);
      if (mix && c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
      push(c, 1'b0);
    end
  endtask

  task automatic push_noise(input int unsigned n);
    for (int k = 0; k < n; k++) push(text_byte(), 1'b0);
  endtask

  // driver
  always @(posedge clk) begin
    reply_t r;
    req_t it;
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        if (scan_byte(in_rx_byte, in_give_up, r)) replies_q.push_back(r);
      end
      if (!busy) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() == 0 || (pend_q[0].drain && replies_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          it = pend_q.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= it.rx;
          in_give_up <= it.gu;
          gap_cnt <= draw_wait(send_burst);
          if ($urandom_range(0, 39) == 0) send_burst <= ~send_burst;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    int unsigned nxt;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      nxt = stall_cnt;
      if (out_valid && out_ready) begin
        got = reply_t'({out_outcome, out_message_code, out_set_rate, out_rate_index});
        if (replies_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d", $time,
                   got.outcome, got.msg, got.set_rate, got.rate);
          err_cnt++;
        end else begin
          want = replies_q.pop_front();
          if (got.outcome !== want.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
            err_cnt++;
          end
          if (got.msg !== want.msg) begin
            $display("%0t: message_code expected %0d actual %0d", $time, want.msg, got.msg);
            err_cnt++;
          end
          if (got.set_rate !== want.set_rate) begin
            $display("%0t: set_rate expected %0d actual %0d", $time, want.set_rate,
                     got.set_rate);
            err_cnt++;
          end
          if (got.rate !== want.rate) begin
            $display("%0t: rate_index expected %0d actual %0d", $time, want.rate, got.rate);
            err_cnt++;
          end
        end
        nxt = draw_wait(recv_burst);
        if ($urandom_range(0, 29) == 0) recv_burst <= ~recv_burst;
      end else if (nxt > 0) begin
        nxt--;
      end
      stall_cnt <= nxt;
      out_ready <= (nxt == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin
    int unsigned idx;
    int unsigned kind;
    int unsigned len;
    int unsigned bad;
    int unsigned mark;
    int unsigned start;
    string s;

    // every code in upper case, then two codes in lower and mixed case
    for (int i = 0; i < CODE_COUNT; i++) begin
      push_text(result_text[i], 1'b0, result_text[i].len());
      push(pick_term(), 1'b0);
    end
    push_text("connect 9600", 1'b0, 12);
    push(CHAR_LF, 1'b0);
    push_text("No Dialtone", 1'b0, 11);
    push(CHAR_CR, 1'b0);
    // empty lines
    push(CHAR_CR, 1'b0);
    push(CHAR_LF, 1'b0);
    // abort with extreme byte values, also mid-line
    push(8'hff, 1'b1);
    push(8'h00, 1'b1);
    push_text("CONN", 1'b0, 4);
    push(CHAR_CR, 1'b1);
    push_text("ERROR", 1'b0, 5);
    push(CHAR_CR, 1'b0);
    // zero byte and non-ascii bytes
    push(8'h00, 1'b0);
    push(CHAR_CR, 1'b0);
    push(8'hc2, 1'b0);
    push(8'hff, 1'b0);
    push(CHAR_LF, 1'b0);
    // prefix and suffix mismatches
    push_text("CONNECT 1", 1'b0, 9);
    push(CHAR_CR, 1'b0);
    push_text("BUSY ", 1'b0, 5);
    push(CHAR_CR, 1'b0);
    // longest line kept, then line reaching the limit
    push_noise(LINE_LIMIT - 1);
    push(CHAR_CR, 1'b0);
    push_noise(LINE_LIMIT);
    push_text("BUSY", 1'b0, 4);
    push(CHAR_LF, 1'b0);

    start = pend_q.size();
    mark = start;
    while (pend_q.size() < start + RAND_ITEMS) begin
      if (pend_q.size() >= mark + 300) begin
        pend_q[$].drain = 1'b1;
        mark = mark + 300;
      end
      kind = $urandom_range(0, 99);
      idx = $urandom_range(0, CODE_COUNT - 1);
      s = result_text[idx];
      if (kind < 60) begin
        if ($urandom_range(0, 9) == 0) push(pick_term(), 1'b0);
        push_text(s, 1'b1, s.len());
        push(pick_term(), 1'b0);
      end else if (kind < 70) begin
        if ($urandom_range(0, 1)) begin
          push_text(s, 1'b1, $urandom_range(0, s.len() - 1));
        end else begin
          bad = $urandom_range(0, s.len() - 1);
          push_text(s, 1'b1, bad);
          push(text_byte(), 1'b0);
          push_text(s.substr(bad + 1, s.len() - 1), 1'b1, s.len());
        end
        push(pick_term(), 1'b0);
      end else if (kind < 78) begin
        push_text(s, 1'b1, $urandom_range(0, s.len()));
        push(8'($urandom_range(0, 255)), 1'b1);
      end else if (kind < 85) begin
        push_noise($urandom_range(1, 10));
        push(pick_term(), 1'b0);
      end else if (kind < 90) begin
        len = $urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 4);
        push_noise(len);
        push(pick_term(), 1'b0);
      end else begin
        push(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid || replies_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, replies_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ modem_result_code_matcher.f @@
+incdir+rtl/core
rtl/core/mrcm_pkg.sv
rtl/core/mrcm_line_match.sv
rtl/core/modem_result_code_matcher.sv
tb/tb.sv
